// ----- rtl/core/assert_macros.svh -----
// Assertion helpers; clk and rst_n must be visible where these are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define PCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define PCD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pcd_pkg.sv -----
package pcd_pkg;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_DECODE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;

    typedef struct packed {
        logic [1:0]        func;
        logic [7:0]        entry_symbol;
        logic [CODE_W-1:0] entry_code;
        logic [LEN_W-1:0]  entry_length;
        logic              stream_bit;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       status;
    } out_word_t;

    // Controller to datapath
    typedef struct packed {
        logic load_en;
        logic clear_en;
        logic decode_start;
        logic rd_issue;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic result_pending;
        logic out_free;
    } ctrl_sts_t;

    function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] len);
        logic [CODE_W-1:0] m;
        if (len >= LEN_W'(CODE_W))
        begin
            m = '1;
        end
        else
        begin
            m = (CODE_W'(1) << len) - CODE_W'(1);
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/pcd_datapath.sv -----
module pcd_datapath #(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pcd_pkg::in_word_t  item,
    input  pcd_pkg::ctrl_cmd_t cmd,
    output pcd_pkg::ctrl_sts_t sts,
    output logic               result_valid,
    input  logic               result_stall,
    output pcd_pkg::out_word_t result
);

    `include "assert_macros.svh"

    localparam int SYM_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int LIMIT_HI = (MAX_CODE_LEN > pcd_pkg::CODE_W) ? pcd_pkg::CODE_W
                                                               : MAX_CODE_LEN;
    localparam int LIMIT = (LIMIT_HI < 1) ? 1 : LIMIT_HI;
    localparam int ENT_W = pcd_pkg::LEN_W + pcd_pkg::CODE_W;
    localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(NUM_SYMBOLS - 1);

    logic [ENT_W-1:0] ent_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] ent_valid_reg;

    logic [ENT_W-1:0] rd_data_reg;
    logic             rd_ent_valid_reg;
    logic             rd_valid_reg;
    logic [SYM_W-1:0] rd_idx_reg;
    logic [SYM_W-1:0] scan_cnt_reg, scan_cnt_next;

    logic [pcd_pkg::CODE_W-1:0] partial_bits_reg, partial_bits_next;
    logic [pcd_pkg::LEN_W-1:0]  partial_count_reg, partial_count_next;
    logic                       found_reg, found_next;
    logic [SYM_W-1:0]           hit_reg, hit_next;

    logic                   out_valid_reg, out_valid_next;
    pcd_pkg::out_word_t     out_word_reg;

    logic                       sym_ok;
    logic [SYM_W-1:0]           wr_addr;
    logic [pcd_pkg::LEN_W-1:0]  rd_len;
    logic [pcd_pkg::CODE_W-1:0] rd_bits;
    logic                       match;

    assign sym_ok  = {1'b0, item.entry_symbol} < 9'(NUM_SYMBOLS);
    assign wr_addr = item.entry_symbol[SYM_W-1:0];

    // Table store: writes only while idle, reads only while scanning
    always_ff @(posedge clk)
    begin
        if (cmd.load_en && sym_ok)
        begin
            ent_mem[wr_addr] <= {item.entry_length,
                                 item.entry_code & pcd_pkg::low_mask(item.entry_length)};
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg      <= ent_mem[scan_cnt_reg];
            rd_ent_valid_reg <= ent_valid_reg[scan_cnt_reg];
            rd_idx_reg       <= scan_cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
        end
        else if (cmd.load_en && sym_ok)
        begin
            ent_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // An entry never loaded reads as absent
    assign rd_len  = rd_ent_valid_reg ? rd_data_reg[ENT_W-1 -: pcd_pkg::LEN_W]
                                      : '0;
    assign rd_bits = rd_data_reg[pcd_pkg::CODE_W-1:0];
    // Bits above the count stay zero, so a plain compare suffices
    assign match   = rd_valid_reg && (rd_len == partial_count_reg)
                     && (rd_bits == partial_bits_reg);

    always_comb
    begin
        scan_cnt_next      = scan_cnt_reg;
        partial_bits_next  = partial_bits_reg;
        partial_count_next = partial_count_reg;
        found_next         = found_reg;
        hit_next           = hit_reg;
        out_valid_next     = out_valid_reg && result_stall;

        if (cmd.decode_start)
        begin
            scan_cnt_next = '0;
        end
        else if (cmd.rd_issue)
        begin
            scan_cnt_next = scan_cnt_reg + SYM_W'(1);
        end

        if (cmd.clear_en || cmd.emit)
        begin
            partial_bits_next  = '0;
            partial_count_next = '0;
        end
        else if (cmd.decode_start)
        begin
            partial_bits_next  = {partial_bits_reg[pcd_pkg::CODE_W-2:0], item.stream_bit};
            partial_count_next = partial_count_reg + pcd_pkg::LEN_W'(1);
        end

        // Later matches override earlier ones: highest symbol wins
        if (cmd.decode_start)
        begin
            found_next = 1'b0;
        end
        else if (match)
        begin
            found_next = 1'b1;
            hit_next   = rd_idx_reg;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg      <= '0;
            rd_valid_reg      <= 1'b0;
            partial_bits_reg  <= '0;
            partial_count_reg <= '0;
            found_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            scan_cnt_reg      <= scan_cnt_next;
            rd_valid_reg      <= cmd.rd_issue;
            partial_bits_reg  <= partial_bits_next;
            partial_count_reg <= partial_count_next;
            found_reg         <= found_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        if (cmd.emit)
        begin
            out_word_reg.out_symbol <= found_reg ? 8'(hit_reg) : 8'd0;
            out_word_reg.status     <= !found_reg;
        end
    end

    assign sts.scan_last      = (scan_cnt_reg == LAST_SYM);
    assign sts.result_pending = found_reg || (partial_count_reg >= pcd_pkg::LEN_W'(LIMIT));
    assign sts.out_free       = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

    `PCD_ASSERT_IMPLY(a_emit_free, cmd.emit, (!out_valid_reg || !result_stall), "result overwritten while stalled")
    `PCD_ASSERT(a_count_limit, partial_count_reg <= pcd_pkg::LEN_W'(LIMIT), "partial code past limit")
    `PCD_ASSERT_NEXT(a_emit_clears, cmd.emit, (partial_count_reg == '0 && out_valid_reg), "emit did not clear partial code")
    `PCD_ASSERT_IMPLY(a_no_rw_clash, cmd.load_en, (!cmd.rd_issue && !rd_valid_reg), "table write during scan")

endmodule

// ----- rtl/core/pcd_ctrl.sv -----
module pcd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         item_func,
    input  pcd_pkg::ctrl_sts_t sts,
    output pcd_pkg::ctrl_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;
    localparam logic [1:0] ST_RESOLVE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_en      = (item_func == pcd_pkg::FUNC_LOAD);
                    cmd.clear_en     = (item_func == pcd_pkg::FUNC_CLEAR);
                    cmd.decode_start = (item_func == pcd_pkg::FUNC_DECODE);
                    if (item_func == pcd_pkg::FUNC_DECODE)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_issue = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                // With no result pending return to idle; else hold until the output register can take the result
                if (!sts.result_pending)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/core/prefix_code_bit_decoder_top.sv -----
// Load, clear and unused words: accepted in one cycle, next word taken the cycle after.
// Decode word: the result follows a scan of the one-port code table, one entry per cycle;
// no new word is taken until the decode is done, and a waiting result adds stall.
// Reset (rst_n, async, low): table empty, partial code clear, no result pending.
module prefix_code_bit_decoder_top #(
    parameter int MAX_CODE_LEN = 32,
    parameter int NUM_SYMBOLS  = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    // Input words: load entry, decode one bit, or clear partial code
    input  logic               item_valid,
    output logic               item_stall,
    input  pcd_pkg::in_word_t  item,
    // Result words: decoded symbol or overflow status
    output logic               result_valid,
    input  logic               result_stall,
    output pcd_pkg::out_word_t result
);

    pcd_pkg::ctrl_cmd_t cmd;
    pcd_pkg::ctrl_sts_t sts;

    // Controller: sequence one word at a time; a decode walks every table
    // entry, drains the read pipe, then hands any pending outcome to the output register.
    pcd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_func  (item.func),
        .sts        (sts),
        .cmd        (cmd)
    );

    // Datapath: code table with per-entry valid bits, partial code,
    // match tracking (highest symbol wins) and the output register that
    // decouples a stalled result from the next input word.
    pcd_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .NUM_SYMBOLS  (NUM_SYMBOLS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
